FILE: hdl/irc_join_nick_extractor_assert.svh
// Assertion macros for the IRC JOIN/NICK name extractor.
// Taken in by the checker module; depends on nothing else.
`ifndef IRC_JOIN_NICK_EXTRACTOR_ASSERT_SVH
`define IRC_JOIN_NICK_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define IJN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define IJN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define IJN_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ijn_pkg.sv
// Shared types for the IRC JOIN/NICK name extractor.
// Used by every module of the block; depends on nothing.
package ijn_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       from_responder;
      logic       segment_end;
   } req_word_type;

   typedef struct packed {
      logic       name_kind;
      logic [7:0] name_byte;
      logic       last_of_name;
   } rsp_word_type;

   // Up to two result words produced by the parser for one input word.
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } push_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } head_type;

endpackage

FILE: hdl/irc_join_nick_extractor.sv
// Top level of the IRC JOIN/NICK name extractor.
// Instantiates ijn_front, ijn_queue and ijn_back; depends on ijn_pkg.
//
// The block takes one client-to-server payload word per clock while req_stall is
// low and gives out the channel names of JOIN lines and the nicknames of NICK
// lines, one byte per result word, with the final byte of each name flagged. The
// parser accepts a word in every cycle in which its four-entry result queue has at
// least two free places, so req_stall rises only when the rsp side has been stalled
// for a while. Results reach rsp via the queue and the registered output stage.
module irc_join_nick_extractor (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ijn_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ijn_pkg::rsp_word_type rsp_data
);
   import ijn_pkg::*;

   push_type push;
   head_type head;
   logic     room;
   logic     pop;
   logic     fire;

   assign req_stall = !room;
   assign fire      = req_valid && room;

   ijn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_data (req_data),
      .push     (push)
   );

   ijn_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .room  (room)
   );

   ijn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/ijn_front.sv
// Parser front end: classifies each input byte and produces result words.
// Depends on ijn_pkg.
module ijn_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  ijn_pkg::req_word_type req_data,
   output ijn_pkg::push_type    push
);
   import ijn_pkg::*;

   localparam logic [1:0] PH_LINE  = 2'd0;
   localparam logic [1:0] PH_MATCH = 2'd1;
   localparam logic [1:0] PH_NAME  = 2'd2;
   localparam logic [1:0] PH_SKIP  = 2'd3;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [2:0] PREFIX_LEN  = 3'd5;
   localparam logic [2:0] PREFIX_LAST = 3'd4;
   localparam logic       KIND_CHANNEL = 1'b0;
   localparam logic       KIND_NICK    = 1'b1;

   function automatic logic [7:0] prefix_char(input logic kind, input logic [2:0] pos);
      logic [7:0] c;
      unique case ({kind, pos})
         {KIND_CHANNEL, 3'd0}: c = "J";
         {KIND_CHANNEL, 3'd1}: c = "O";
         {KIND_CHANNEL, 3'd2}: c = "I";
         {KIND_CHANNEL, 3'd3}: c = "N";
         {KIND_CHANNEL, 3'd4}: c = CHAR_SPACE;
         {KIND_NICK, 3'd0}:    c = "N";
         {KIND_NICK, 3'd1}:    c = "I";
         {KIND_NICK, 3'd2}:    c = "C";
         {KIND_NICK, 3'd3}:    c = "K";
         {KIND_NICK, 3'd4}:    c = CHAR_SPACE;
         default:              c = CHAR_NUL;
      endcase
      return c;
   endfunction

   logic [1:0] phase_ff, phase_in;
   logic [2:0] pos_ff, pos_in;
   logic       kind_ff, kind_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;

   logic [7:0] b;
   logic       is_lf;
   logic       is_term;
   logic       seg;

   assign b       = req_data.data_byte;
   assign seg     = req_data.segment_end;
   assign is_lf   = (b == CHAR_LF);
   assign is_term = is_lf || (b == CHAR_CR) || (b == CHAR_SPACE);

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      kind_in       = kind_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      push          = '0;
      if (fire && !req_data.from_responder) begin
         unique case (phase_ff)
            PH_SKIP: begin
               if (is_lf) begin
                  phase_in = PH_LINE;
               end
            end
            PH_NAME: begin
               if (is_term) begin
                  if (held_valid_ff) begin
                     push.count = 2'd1;
                     push.first = '{kind_ff, held_byte_ff, 1'b1};
                  end
                  held_valid_in = 1'b0;
                  phase_in      = is_lf ? PH_LINE : PH_SKIP;
               end else begin
                  if (held_valid_ff) begin
                     push.first = '{kind_ff, held_byte_ff, 1'b0};
                     if (seg) begin
                        push.count  = 2'd2;
                        push.second = '{kind_ff, b, 1'b1};
                     end else begin
                        push.count = 2'd1;
                     end
                  end else if (seg) begin
                     push.count = 2'd1;
                     push.first = '{kind_ff, b, 1'b1};
                  end
                  held_byte_in  = b;
                  held_valid_in = !seg;
               end
            end
            PH_MATCH: begin
               if ((pos_ff < PREFIX_LEN) && (prefix_char(kind_ff, pos_ff) == b)) begin
                  pos_in = pos_ff + 3'd1;
                  if (pos_ff == PREFIX_LAST) begin
                     held_valid_in = 1'b0;
                     phase_in      = PH_NAME;
                  end
               end else begin
                  pos_in   = 3'd0;
                  phase_in = is_lf ? PH_LINE : PH_SKIP;
               end
            end
            PH_LINE: begin
               if (b == CHAR_NUL) begin
                  phase_in = PH_LINE;
               end else if (b == prefix_char(KIND_CHANNEL, 3'd0)) begin
                  kind_in  = KIND_CHANNEL;
                  pos_in   = 3'd1;
                  phase_in = PH_MATCH;
               end else if (b == prefix_char(KIND_NICK, 3'd0)) begin
                  kind_in  = KIND_NICK;
                  pos_in   = 3'd1;
                  phase_in = PH_MATCH;
               end else begin
                  pos_in   = 3'd0;
                  phase_in = is_lf ? PH_LINE : PH_SKIP;
               end
            end
         endcase
         // A segment end closes everything except a line skip.
         if (seg && (phase_ff != PH_SKIP)) begin
            held_valid_in = 1'b0;
            pos_in        = 3'd0;
            phase_in      = PH_LINE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LINE;
         pos_ff        <= 3'd0;
         kind_ff       <= KIND_CHANNEL;
         held_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         kind_ff       <= kind_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

endmodule

FILE: hdl/ijn_queue.sv
// Four-entry result queue between parser and output stage; takes up to two words a cycle while it has room.
// Depends on ijn_pkg.
module ijn_queue (
   input  logic              clock,
   input  logic              reset,
   input  ijn_pkg::push_type push,
   input  logic              pop,
   output ijn_pkg::head_type head,
   output logic              room
);
   import ijn_pkg::*;

   localparam int QUEUE_DEPTH = 4;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   rsp_word_type     entry_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] wr_ptr_next;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign wr_ptr_next = wr_ptr_ff + IDX_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + IDX_W'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + IDX_W'(pop);
   assign count_in    = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   assign head.valid = (count_ff != '0);
   assign head.word  = entry_ff[rd_ptr_ff];
   assign room       = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

FILE: hdl/ijn_back.sv
// Output stage: holds one result word on the rsp channel and drains the queue.
// Depends on ijn_pkg.
module ijn_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ijn_pkg::head_type     head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ijn_pkg::rsp_word_type rsp_data
);
   import ijn_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;
   logic         load;

   assign load         = !rsp_valid_ff || !rsp_stall;
   assign pop          = load && head.valid;
   assign rsp_valid_in = load ? head.valid : rsp_valid_ff;
   assign rsp_data_in  = pop ? head.word : rsp_data_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: hdl/ijn_checker.sv
// Port-level checks for the IRC JOIN/NICK name extractor, bound to the top level.
// Depends on ijn_pkg and irc_join_nick_extractor_assert.svh.
`include "irc_join_nick_extractor_assert.svh"

module ijn_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input ijn_pkg::req_word_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input ijn_pkg::rsp_word_type rsp_data
);
   import ijn_pkg::*;

   `IJN_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid, "rsp_valid high after reset")

   `IJN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result word changed")

   `IJN_ASSERT_SAME(a_stall_needs_output, clock, reset, req_stall, rsp_valid, "input stalled while the output is empty")

   `IJN_ASSERT_SAME(a_result_has_source, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall && !req_data.from_responder, 2), "result word without a client word taken two cycles before")

endmodule

bind irc_join_nick_extractor ijn_checker u_checker (.*);
